### sv/ffvd_pkg.sv
// Package for the FIT field value decoder: status and kind codes, stage words,
// the base type table and byte mask helpers. No dependencies.
package ffvd_pkg;

  typedef enum logic [2:0] {
    ST_INT     = 3'd0,
    ST_FLOAT   = 3'd1,
    ST_STRING  = 3'd2,
    ST_ARRAY   = 3'd3,
    ST_INVALID = 3'd4,
    ST_UNKNOWN = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    KIND_UNSIGNED = 3'd0,
    KIND_SIGNED   = 3'd1,
    KIND_FLOAT    = 3'd2,
    KIND_STRING   = 3'd3,
    KIND_ARRAY    = 3'd4
  } kind_t;

  localparam int unsigned WordBytes = 8;

  typedef struct packed {
    logic        known;
    logic [3:0]  len;
    kind_t       kind;
    logic [63:0] invalid;
  } type_info_t;

  typedef struct packed {
    logic [7:0]  field_id;
    logic        swap_en;
    logic [3:0]  n;
    type_info_t  info;
    logic [63:0] bytes;
  } s1_t;

  typedef struct packed {
    logic [7:0]  field_id;
    type_info_t  info;
    logic [63:0] v;
  } s2_t;

  typedef struct packed {
    status_t     status;
    logic [7:0]  field_id;
    logic [63:0] value;
  } s3_t;

  function automatic type_info_t type_lookup(input logic [7:0] code);
    type_info_t t;
    t = '{known: 1'b1, len: 4'd0, kind: KIND_UNSIGNED, invalid: 64'h0};
    case (code)
      8'h00: begin t.len = 4'd1; t.kind = KIND_UNSIGNED; t.invalid = 64'hFF; end
      8'h01: begin t.len = 4'd1; t.kind = KIND_SIGNED;   t.invalid = 64'h7F; end
      8'h02: begin t.len = 4'd1; t.kind = KIND_UNSIGNED; t.invalid = 64'hFF; end
      8'h83: begin t.len = 4'd2; t.kind = KIND_SIGNED;   t.invalid = 64'h7FFF; end
      8'h84: begin t.len = 4'd2; t.kind = KIND_UNSIGNED; t.invalid = 64'hFFFF; end
      8'h85: begin t.len = 4'd4; t.kind = KIND_SIGNED;   t.invalid = 64'h7FFF_FFFF; end
      8'h86: begin t.len = 4'd4; t.kind = KIND_UNSIGNED; t.invalid = 64'hFFFF_FFFF; end
      8'h07: begin t.len = 4'd0; t.kind = KIND_STRING;   t.invalid = 64'h0; end
      8'h88: begin t.len = 4'd4; t.kind = KIND_FLOAT;    t.invalid = 64'hFFFF_FFFF; end
      8'h89: begin t.len = 4'd8; t.kind = KIND_FLOAT;    t.invalid = '1; end
      8'h0A: begin t.len = 4'd1; t.kind = KIND_UNSIGNED; t.invalid = 64'h0; end
      8'h8B: begin t.len = 4'd2; t.kind = KIND_UNSIGNED; t.invalid = 64'h0; end
      8'h8C: begin t.len = 4'd4; t.kind = KIND_UNSIGNED; t.invalid = 64'h0; end
      8'h0D: begin t.len = 4'd0; t.kind = KIND_ARRAY;    t.invalid = 64'h0; end
      8'h8E: begin t.len = 4'd8; t.kind = KIND_SIGNED;   t.invalid = 64'h7FFF_FFFF_FFFF_FFFF; end
      8'h8F: begin t.len = 4'd8; t.kind = KIND_UNSIGNED; t.invalid = '1; end
      8'h90: begin t.len = 4'd8; t.kind = KIND_UNSIGNED; t.invalid = 64'h0; end
      default: begin t.known = 1'b0; end
    endcase
    return t;
  endfunction

  function automatic logic [63:0] byte_mask(input logic [3:0] len);
    logic [63:0] m;
    m = '0;
    for (int j = 0; j < WordBytes; j++) begin
      if (4'(j) < len) begin
        m[8*j +: 8] = 8'hFF;
      end
    end
    return m;
  endfunction

endpackage

### sv/ffvd_in_if.sv
// Input channel of the FIT field value decoder: one field word per handshake.
// Depends on nothing.
interface ffvd_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  base_type;
  logic [7:0]  field_size;
  logic        swap_bytes;
  logic [7:0]  field_number;
  logic [63:0] raw_bytes;

  modport source (output valid, base_type, field_size, swap_bytes, field_number, raw_bytes,
                  input ready);
  modport sink (input valid, base_type, field_size, swap_bytes, field_number, raw_bytes,
                output ready);
endinterface

### sv/ffvd_out_if.sv
// Result channel of the FIT field value decoder: one decoded word per handshake.
// Depends on nothing.
interface ffvd_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [7:0]  field_id;
  logic [63:0] value;

  modport source (output valid, status, field_id, value, input ready);
  modport sink (input valid, status, field_id, value, output ready);
endinterface

### sv/fit_field_value_decoder.sv
// FIT field value decoder, top level: three register stages (table lookup,
// byte alignment, invalid check and extension). Depends on ffvd_pkg,
// ffvd_in_if, ffvd_out_if, ffvd_lookup, ffvd_align and ffvd_resolve.
//
// Takes one field word per clock while the result side does not stall, and
// returns its decoded word through the three stage registers, each of which
// advances when it is empty or the stage after it takes its word, so a stall
// on the result side backs up stage by stage without losing or repeating a
// word. Bytes at or above MAX_FIELD_BYTES read as zero.
module fit_field_value_decoder #(
  parameter int unsigned MAX_FIELD_BYTES = 8
) (
  input  logic       clk,
  input  logic       rst_n,
  ffvd_in_if.sink    in_word,
  ffvd_out_if.source out_word
);
  import ffvd_pkg::*;

  logic s1_valid;
  logic s1_ready;
  s1_t  s1_data;
  logic s2_valid;
  logic s2_ready;
  s2_t  s2_data;
  s3_t  s3_data;

  ffvd_lookup #(
    .MAX_FIELD_BYTES(MAX_FIELD_BYTES)
  ) u_lookup (
    .clk          (clk),
    .rst_n        (rst_n),
    .valid_i      (in_word.valid),
    .ready_o      (in_word.ready),
    .base_type    (in_word.base_type),
    .field_size   (in_word.field_size),
    .swap_bytes   (in_word.swap_bytes),
    .field_number (in_word.field_number),
    .raw_bytes    (in_word.raw_bytes),
    .valid_o      (s1_valid),
    .ready_i      (s1_ready),
    .data_o       (s1_data)
  );

  ffvd_align u_align (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (s1_valid),
    .ready_o (s1_ready),
    .data_i  (s1_data),
    .valid_o (s2_valid),
    .ready_i (s2_ready),
    .data_o  (s2_data)
  );

  ffvd_resolve u_resolve (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (s2_valid),
    .ready_o (s2_ready),
    .data_i  (s2_data),
    .valid_o (out_word.valid),
    .ready_i (out_word.ready),
    .data_o  (s3_data)
  );

  assign out_word.status   = s3_data.status;
  assign out_word.field_id = s3_data.field_id;
  assign out_word.value    = s3_data.value;
endmodule

### sv/ffvd_lookup.sv
// Stage 1: base type table lookup and trim of the raw bytes to the carried length.
// Depends on ffvd_pkg.
module ffvd_lookup #(
  parameter int unsigned MAX_FIELD_BYTES = 8
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           valid_i,
  output logic           ready_o,
  input  logic [7:0]     base_type,
  input  logic [7:0]     field_size,
  input  logic           swap_bytes,
  input  logic [7:0]     field_number,
  input  logic [63:0]    raw_bytes,
  output logic           valid_o,
  input  logic           ready_i,
  output ffvd_pkg::s1_t  data_o
);
  import ffvd_pkg::*;

  logic  valid_r;
  s1_t   data_r;
  s1_t   data_nxt;

  always_comb begin
    data_nxt.field_id = field_number;
    data_nxt.swap_en  = swap_bytes & base_type[7];
    data_nxt.n        = (field_size < 8'(MAX_FIELD_BYTES)) ? field_size[3:0]
                                                           : 4'(MAX_FIELD_BYTES);
    data_nxt.info     = type_lookup(base_type);
    data_nxt.bytes    = raw_bytes & byte_mask(data_nxt.n);
  end

  assign ready_o = ~valid_r | ready_i;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ready_o) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_o && valid_i) begin
      data_r <= data_nxt;
    end
  end

  assign valid_o = valid_r;
  assign data_o  = data_r;
endmodule

### sv/ffvd_align.sv
// Stage 2: reverse the carried bytes when swap applies, keep the type's length.
// Depends on ffvd_pkg.
module ffvd_align (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           valid_i,
  output logic           ready_o,
  input  ffvd_pkg::s1_t  data_i,
  output logic           valid_o,
  input  logic           ready_i,
  output ffvd_pkg::s2_t  data_o
);
  import ffvd_pkg::*;

  logic        valid_r;
  s2_t         data_r;
  s2_t         data_nxt;
  logic [63:0] rev;
  logic [63:0] sel;

  always_comb begin
    rev = '0;
    for (int k = 0; k < WordBytes; k++) begin
      logic [3:0] src;
      src = data_i.n - 4'(k) - 4'd1;
      if (4'(k) < data_i.n) begin
        rev[8*k +: 8] = data_i.bytes[8*src[2:0] +: 8];
      end
    end
    sel = data_i.swap_en ? rev : data_i.bytes;
    data_nxt.field_id = data_i.field_id;
    data_nxt.info     = data_i.info;
    data_nxt.v        = sel & byte_mask(data_i.info.len);
  end

  assign ready_o = ~valid_r | ready_i;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ready_o) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_o && valid_i) begin
      data_r <= data_nxt;
    end
  end

  assign valid_o = valid_r;
  assign data_o  = data_r;
endmodule

### sv/ffvd_resolve.sv
// Stage 3: invalid pattern check, sign extension and status; holds the output word.
// Depends on ffvd_pkg.
module ffvd_resolve (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           valid_i,
  output logic           ready_o,
  input  ffvd_pkg::s2_t  data_i,
  output logic           valid_o,
  input  logic           ready_i,
  output ffvd_pkg::s3_t  data_o
);
  import ffvd_pkg::*;

  logic  valid_r;
  s3_t   data_r;
  s3_t   data_nxt;
  logic  sign;

  always_comb begin
    case (data_i.info.len)
      4'd1:    sign = data_i.v[7];
      4'd2:    sign = data_i.v[15];
      4'd4:    sign = data_i.v[31];
      default: sign = 1'b0;
    endcase
    data_nxt.field_id = data_i.field_id;
    data_nxt.status   = ST_UNKNOWN;
    data_nxt.value    = '0;
    if (data_i.info.known) begin
      case (data_i.info.kind)
        KIND_STRING: data_nxt.status = ST_STRING;
        KIND_ARRAY:  data_nxt.status = ST_ARRAY;
        KIND_FLOAT: begin
          if (data_i.v == data_i.info.invalid) begin
            data_nxt.status = ST_INVALID;
          end else begin
            data_nxt.status = ST_FLOAT;
            data_nxt.value  = data_i.v;
          end
        end
        KIND_SIGNED, KIND_UNSIGNED: begin
          if (data_i.v == data_i.info.invalid) begin
            data_nxt.status = ST_INVALID;
          end else begin
            data_nxt.status = ST_INT;
            data_nxt.value  = data_i.v;
            if (data_i.info.kind == KIND_SIGNED && sign) begin
              data_nxt.value = data_i.v | ~byte_mask(data_i.info.len);
            end
          end
        end
        default: data_nxt.status = ST_UNKNOWN;
      endcase
    end
  end

  assign ready_o = ~valid_r | ready_i;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ready_o) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_o && valid_i) begin
      data_r <= data_nxt;
    end
  end

  assign valid_o = valid_r;
  assign data_o  = data_r;
endmodule
